// ===== hdl/mqf_pkg.sv =====
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared constants, codes and types of the multi-queue FIFO manager.
// ----------------------------------------------------------------------------
package mqf_pkg;

  localparam int NUM_QUEUES_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Fixed field widths of the item and result channels
  localparam int QIDX_W   = 4;
  localparam int VALUE_W  = 16;
  localparam int SERVED_W = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_HEAD
  } state_t;

endpackage

// ===== hdl/mqf_desc_mem.sv =====
// ----------------------------------------------------------------------------
// mqf_desc_mem
// Queue descriptor memory: one word per queue, registered read, per-entry
// valid bits so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
module mqf_desc_mem #(
  parameter int DEPTH = mqf_pkg::NUM_QUEUES_DEF,
  parameter int DW    = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                            wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                            rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Read of an unwritten entry returns the reset descriptor (all zero)
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

// ===== hdl/mqf_entry_mem.sv =====
// ----------------------------------------------------------------------------
// mqf_entry_mem
// Shared entry store for all queue rings, one write and one registered read.
// ----------------------------------------------------------------------------
module mqf_entry_mem #(
  parameter int DEPTH = mqf_pkg::NUM_QUEUES_DEF * mqf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [mqf_pkg::VALUE_W-1:0]              wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [mqf_pkg::VALUE_W-1:0]              rdata
);

  logic [mqf_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/multi_queue_fifo_manager.sv =====
// ----------------------------------------------------------------------------
// multi_queue_fifo_manager
// Set of independent FIFO rings, one per queue, held in one shared store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries one request item: s_tuser[0] selects enqueue
//   (0) or dequeue (1), s_tdata names the queue and the value to append.
//   Master channel (m_*) returns exactly one result item per request: status,
//   new queue length, saturating served count and the new head value.
//   Each item passes these steps in order: read the queue descriptor memory,
//   update it (on enqueue also writing the entry store) while the head entry
//   is read, and load the result register. Requests are handled one at a
//   time; no new request is taken until the last result is loaded.
//   The result register parts the two sides: a new request is taken while an
//   earlier result still waits. If the receiver stalls, the finished item
//   holds in the last step until the result register frees up.
//   Reset (rst, synchronous) empties every queue and clears the served
//   counts at once through valid bits on the descriptor memory; the entry
//   store needs no clearing since only the read data of queued entries is used.
// ----------------------------------------------------------------------------
module multi_queue_fifo_manager #(
  parameter int NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // queue_index [3:0], car_number [19:4], zero pad [23:20]
  input  logic [mqf_pkg::S_TDATA_W-1:0]   s_tdata,
  // action [0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [1:0], queue_length [6:2], served_count [22:7],
  // head_value [38:23], head_valid [39]
  output logic [mqf_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QXW = (QW > mqf_pkg::QIDX_W) ? QW : mqf_pkg::QIDX_W;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int DW  = 2 * PW + CW + mqf_pkg::SERVED_W;
  localparam int ED  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int EAW = (ED > 1) ? $clog2(ED) : 1;
  localparam int VW  = mqf_pkg::VALUE_W;
  localparam int SW  = mqf_pkg::SERVED_W;

  mqf_pkg::state_t state, state_next;

  logic accept;
  logic load_out;

  // Request registers
  logic           act;
  logic [QW-1:0]  qidx;
  logic           qok;
  logic [VW-1:0]  car;

  logic [QXW-1:0] q_ext;
  logic           q_ok_now;

  // Descriptor memory ports
  logic [DW-1:0]  desc_rd;
  logic [DW-1:0]  desc_wr;
  logic           desc_we;

  logic [PW-1:0]  d_head, d_tail;
  logic [CW-1:0]  d_count;
  logic [SW-1:0]  d_served;

  logic [PW-1:0]  n_head, n_tail;
  logic [CW-1:0]  n_count;
  logic [SW-1:0]  n_served;

  // Entry store ports
  logic           ent_we;
  logic           ent_re;
  logic [EAW-1:0] ent_base;
  logic [EAW-1:0] ent_waddr;
  logic [EAW-1:0] ent_raddr;
  logic [VW-1:0]  ent_rd;

  // Result staging, filled in the descriptor step
  logic [mqf_pkg::STATUS_W-1:0] status_c, status;
  logic [CW-1:0]                len_c, len;
  logic [SW-1:0]                served_c, served;
  logic                         hvalid_c, hvalid;
  logic                         fwd_c, fwd;

  logic [VW-1:0]                head_value;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_ext    = QXW'(s_tdata[mqf_pkg::QIDX_W-1:0]);
  assign q_ok_now = {1'b0, q_ext} < (QXW + 1)'(NUM_QUEUES);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      mqf_pkg::ST_IDLE: if (accept) state_next = mqf_pkg::ST_DESC;
      mqf_pkg::ST_DESC: state_next = mqf_pkg::ST_HEAD;
      mqf_pkg::ST_HEAD: if (load_out) state_next = mqf_pkg::ST_IDLE;
      default:          state_next = mqf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == mqf_pkg::ST_IDLE);
    load_out = (state == mqf_pkg::ST_HEAD) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= s_tuser[0];
      qidx <= q_ext[QW-1:0];
      qok  <= q_ok_now;
      car  <= s_tdata[mqf_pkg::QIDX_W +: VW];
    end
  end

  // ------------------------------------------------------------ descriptor
  mqf_desc_mem #(
    .DEPTH (NUM_QUEUES),
    .DW    (DW)
  ) u_desc_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (desc_we),
    .waddr (qidx),
    .wdata (desc_wr),
    .re    (accept && q_ok_now),
    .raddr (q_ext[QW-1:0]),
    .rdata (desc_rd)
  );

  assign {d_served, d_count, d_tail, d_head} = desc_rd;
  assign desc_wr = {n_served, n_count, n_tail, n_head};

  assign ent_base = EAW'(qidx) * EAW'(QUEUE_DEPTH);

  // Modify the descriptor; the head entry read is issued in the same step
  always_comb begin
    n_head    = d_head;
    n_tail    = d_tail;
    n_count   = d_count;
    n_served  = d_served;
    status_c  = mqf_pkg::STATUS_DONE;
    fwd_c     = 1'b0;
    ent_we    = 1'b0;
    desc_we   = 1'b0;
    if (!qok) begin
      status_c = (act == mqf_pkg::ACT_DEQUEUE) ? mqf_pkg::STATUS_EMPTY
                                               : mqf_pkg::STATUS_FULL;
    end else if (act == mqf_pkg::ACT_ENQUEUE) begin
      if (d_count >= CW'(QUEUE_DEPTH)) begin
        status_c = mqf_pkg::STATUS_FULL;
      end else begin
        ent_we  = (state == mqf_pkg::ST_DESC);
        desc_we = (state == mqf_pkg::ST_DESC);
        n_tail  = ring_next(d_tail);
        n_count = d_count + CW'(1);
        // Empty queue: the new entry becomes the head, forward it
        fwd_c   = (d_count == '0);
      end
    end else begin
      if (d_count == '0) begin
        status_c = mqf_pkg::STATUS_EMPTY;
      end else begin
        desc_we  = (state == mqf_pkg::ST_DESC);
        n_head   = ring_next(d_head);
        n_count  = d_count - CW'(1);
        n_served = (d_served == '1) ? d_served : d_served + SW'(1);
      end
    end
    len_c    = qok ? n_count  : '0;
    served_c = qok ? n_served : '0;
    hvalid_c = qok && (n_count != '0);
  end

  assign ent_waddr = ent_base + EAW'(d_tail);
  assign ent_raddr = ent_base + EAW'(n_head);
  assign ent_re    = (state == mqf_pkg::ST_DESC) && qok;

  mqf_entry_mem #(
    .DEPTH (ED)
  ) u_entry_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (car),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  always_ff @(posedge clk) begin
    if (state == mqf_pkg::ST_DESC) begin
      status <= status_c;
      len    <= len_c;
      served <= served_c;
      hvalid <= hvalid_c;
      fwd    <= fwd_c;
    end
  end

  // ---------------------------------------------------------------- result
  assign head_value = !hvalid ? '0 : (fwd ? car : ent_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {hvalid, head_value, served, mqf_pkg::LEN_W'(len), status};
    end
  end

endmodule

// ===== tb/sv/tb_multi_queue_fifo_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_queue_fifo_manager
// Self-checking bench for the multi-queue FIFO manager: a queue-backed
// driver and a scoreboarding monitor run against an in-bench queue predictor
// through directed corners and random traffic under sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_multi_queue_fifo_manager;

  localparam int NQ = mqf_pkg::NUM_QUEUES_DEF;
  localparam int QD = mqf_pkg::QUEUE_DEPTH_DEF;

  // One request item as the bench sees it
  typedef struct {
    logic                        action;
    logic [mqf_pkg::QIDX_W-1:0]  qidx;
    logic [mqf_pkg::VALUE_W-1:0] car;
  } request_t;

  // One result item, unpacked into its fields
  typedef struct {
    logic [mqf_pkg::STATUS_W-1:0] status;
    logic [mqf_pkg::LEN_W-1:0]    length;
    logic [mqf_pkg::SERVED_W-1:0] served;
    logic [mqf_pkg::VALUE_W-1:0]  head;
    logic                         head_ok;
  } outcome_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // queue_index [3:0], car_number [19:4], zero pad [23:20]
  logic [mqf_pkg::S_TDATA_W-1:0] s_tdata = '0;
  // action [0]
  logic [0:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // status [1:0], queue_length [6:2], served_count [22:7],
  // head_value [38:23], head_valid [39]
  logic [mqf_pkg::M_TDATA_W-1:0] m_tdata;

  multi_queue_fifo_manager uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: one ring per queue, mirrored from the block's behavior
  // --------------------------------------------------------------------------
  logic [mqf_pkg::VALUE_W-1:0]  ring_store [NQ][QD];
  int                           ring_head  [NQ] = '{default: 0};
  int                           ring_tail  [NQ] = '{default: 0};
  int                           ring_len   [NQ] = '{default: 0};
  logic [mqf_pkg::SERVED_W-1:0] ring_served[NQ] = '{default: '0};

  request_t request_backlog[$];   // items not yet handed to the driver
  outcome_t pending_outcomes[$];  // results owed by the block, oldest first

  int  pushed_count = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  bit  took_item = 1'b0;          // s-side handshake at the last rising edge

  int       burst_left = 0;
  int       gap_left = 0;
  int       ready_left = 0;
  int       ready_mode = 0;
  request_t next_req;

  // Apply one request to the predicted queues and return the result it owes.
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       q;
    o.status  = mqf_pkg::STATUS_DONE;
    o.length  = '0;
    o.served  = '0;
    o.head    = '0;
    o.head_ok = 1'b0;
    // Out-of-range queue: nothing moves, everything else reads as zero
    if (r.qidx >= NQ) begin
      o.status = (r.action == mqf_pkg::ACT_DEQUEUE) ? mqf_pkg::STATUS_EMPTY
                                                    : mqf_pkg::STATUS_FULL;
      return o;
    end
    q = r.qidx;
    if (r.action == mqf_pkg::ACT_ENQUEUE) begin
      if (ring_len[q] >= QD) begin
        o.status = mqf_pkg::STATUS_FULL;   // drop the value, queue unchanged
      end else begin
        ring_store[q][ring_tail[q]] = r.car;
        ring_tail[q] = (ring_tail[q] + 1) % QD;
        ring_len[q]++;
      end
    end else if (ring_len[q] == 0) begin
      o.status = mqf_pkg::STATUS_EMPTY;
    end else begin
      ring_head[q] = (ring_head[q] + 1) % QD;
      ring_len[q]--;
      // Served count saturates at all ones
      if (ring_served[q] != '1) ring_served[q]++;
    end
    o.length = mqf_pkg::LEN_W'(ring_len[q]);
    o.served = ring_served[q];
    if (ring_len[q] != 0) begin
      o.head    = ring_store[q][ring_head[q]];
      o.head_ok = 1'b1;
    end
    return o;
  endfunction

  // Compare one result word against the oldest owed result.
  task automatic check_outcome(input logic [mqf_pkg::M_TDATA_W-1:0] word);
    outcome_t got;
    outcome_t want;
    got.status  = word[1:0];
    got.length  = word[6:2];
    got.served  = word[22:7];
    got.head    = word[38:23];
    got.head_ok = word[39];
    if (pending_outcomes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] unexpected result: status=%0d len=%0d served=%0d head=%h valid=%b",
                 $realtime, got.status, got.length, got.served, got.head, got.head_ok);
      return;
    end
    want = pending_outcomes.pop_front();
    if (got.status !== want.status || got.length !== want.length ||
        got.served !== want.served || got.head !== want.head ||
        got.head_ok !== want.head_ok) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected: status=%0d len=%0d served=%0d head=%h valid=%b",
                 want.status, want.length, want.served, want.head, want.head_ok);
        $display("  actual:   status=%0d len=%0d served=%0d head=%h valid=%b",
                 got.status, got.length, got.served, got.head, got.head_ok);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the result
  // first so an item accepted on the same edge never pairs with it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      took_item <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_outcome(m_tdata);
      if (s_tvalid && s_tready) begin
        pending_outcomes.push_back(apply_request('{action: s_tuser[0],
                                                   qidx:   s_tdata[3:0],
                                                   car:    s_tdata[19:4]}));
        accepted_count++;
      end
      took_item <= s_tvalid && s_tready;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: present a new item at the falling edge once the previous one was
  // taken; hold it otherwise. Work in bursts of random length with random
  // gaps; some bursts come with no gap at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_item) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        next_req = request_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, next_req.car, next_req.qidx};
        s_tuser  <= next_req.action;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between always ready, coin-flip and mostly stalled
  // stretches of random length.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      2:       m_tready <= 1'($urandom_range(0, 1));
      3:       m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= 1'b1;
    endcase
  end

  task automatic add_request(input logic act, input int q,
                             input logic [mqf_pkg::VALUE_W-1:0] car);
    request_backlog.push_back('{action: act, qidx: q[mqf_pkg::QIDX_W-1:0], car: car});
    pushed_count++;
  endtask

  // Hold until every item went in and every owed result came out.
  task automatic wait_drained();
    while (accepted_count != pushed_count || pending_outcomes.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int              seg;
    int              enq_pct;
    int              qsel;
    bit              narrow;
    logic            act;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed corners: value extremes, empty dequeue, out-of-range queues
    add_request(mqf_pkg::ACT_ENQUEUE, 0, 16'h0000);
    add_request(mqf_pkg::ACT_ENQUEUE, NQ - 1, 16'hFFFF);
    add_request(mqf_pkg::ACT_DEQUEUE, 5, 16'h1234);
    add_request(mqf_pkg::ACT_DEQUEUE, NQ - 1, 16'h0000);
    add_request(mqf_pkg::ACT_DEQUEUE, NQ - 1, 16'hFFFF);
    add_request(mqf_pkg::ACT_ENQUEUE, 15, 16'hA5A5);
    add_request(mqf_pkg::ACT_DEQUEUE, 15, 16'h5A5A);
    add_request(mqf_pkg::ACT_DEQUEUE, NQ, 16'hFFFF);
    // Fill one queue to the brim, then push one more to see it dropped
    for (int i = 0; i <= QD; i++)
      add_request(mqf_pkg::ACT_ENQUEUE, 3, 16'($urandom()));
    wait_drained();

    // Random traffic: alternate enqueue-heavy and dequeue-heavy segments so
    // queues reach both full and empty; the first two crowd a few queues.
    // Drain between segments so the sender sits idle until all results land.
    for (seg = 0; seg < 4; seg++) begin
      enq_pct = (seg % 2 == 0) ? 75 : 25;
      narrow  = (seg < 2);
      repeat (175) begin
        if ($urandom_range(0, 99) < 12)
          qsel = $urandom_range(NQ, 15);
        else if (narrow)
          qsel = $urandom_range(0, 2);
        else
          qsel = $urandom_range(0, NQ - 1);
        act = ($urandom_range(0, 99) < enq_pct) ? mqf_pkg::ACT_ENQUEUE
                                                : mqf_pkg::ACT_DEQUEUE;
        add_request(act, qsel, 16'($urandom()));
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mqf_pkg.sv
hdl/mqf_desc_mem.sv
hdl/mqf_entry_mem.sv
hdl/multi_queue_fifo_manager.sv
tb/sv/tb_multi_queue_fifo_manager.sv
